// ===== design/mlfr_pkg.sv =====
// ----------------------------------------------------------------------------
// mlfr_pkg
// Shared types and constants for the magic-word, length-prefixed deframer.
// ----------------------------------------------------------------------------
package mlfr_pkg;

   localparam int HDR_BYTES   = 16;
   localparam int HDR_IDX_W   = $clog2(HDR_BYTES);
   localparam int CNT_OFFSET  = 12;
   localparam int WORD_BYTES  = 4;
   localparam int MAGIC_W     = 32;
   localparam int MAX_WORDS_W = 21;
   localparam int REM_W       = 23;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [MAX_WORDS_W-1:0] COUNT_LIMIT = MAX_WORDS_W'(1 << 20);

   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_WORD = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_WORDS = CSR_IDX_W'(1);

   typedef logic [7:0] byte_type;

   // Result of checking a completed header window
   typedef struct packed {
      logic                   hdr_ok;
      logic [MAX_WORDS_W-1:0] count;
   } hdr_status_type;

   // Commands from the frame control to the output stage
   typedef struct packed {
      logic     body_load;
      logic     body_last;
      byte_type body_byte;
      logic     hdr_load;
   } tx_cmd_type;

endpackage

// ===== design/mlfr_window.sv =====
// ----------------------------------------------------------------------------
// mlfr_window
// Header window: collects bytes, checks magic and word count on the byte
// that fills it, and slides one byte on a failed check.
// ----------------------------------------------------------------------------
module mlfr_window
   import mlfr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  byte_type               push_byte,
   input  logic [MAGIC_W-1:0]     sync_word,
   input  logic [MAX_WORDS_W-1:0] limit,
   input  logic [HDR_IDX_W-1:0]   rd_idx,
   output byte_type               rd_byte,
   output hdr_status_type         status
);

   byte_type               win_ff [HDR_BYTES];
   byte_type               win_in [HDR_BYTES];
   byte_type               cand   [HDR_BYTES];
   logic [HDR_IDX_W-1:0]   fill_ff, fill_in;
   logic                   full;
   logic [MAGIC_W-1:0]     magic_word;
   logic [31:0]            count_word;
   logic                   count_ok;

   always_comb begin
      for (int i = 0; i < HDR_BYTES; i++) begin
         cand[i] = (fill_ff == HDR_IDX_W'(i)) ? push_byte : win_ff[i];
      end
   end

   assign full       = (fill_ff == HDR_IDX_W'(HDR_BYTES - 1));
   assign magic_word = {cand[3], cand[2], cand[1], cand[0]};
   assign count_word = {cand[CNT_OFFSET+3], cand[CNT_OFFSET+2],
                        cand[CNT_OFFSET+1], cand[CNT_OFFSET]};
   assign count_ok   = (count_word[31:MAX_WORDS_W] == '0) &&
                       (count_word[MAX_WORDS_W-1:0] <= limit);

   assign status.hdr_ok = full && (magic_word == sync_word) && count_ok;
   assign status.count  = count_word[MAX_WORDS_W-1:0];

   assign rd_byte = win_ff[rd_idx];

   always_comb begin
      fill_in = fill_ff;
      for (int i = 0; i < HDR_BYTES; i++) begin
         win_in[i] = win_ff[i];
      end
      if (push) begin
         if (full && !status.hdr_ok) begin
            // drop the oldest byte and look again on the next request
            for (int i = 0; i < HDR_BYTES - 1; i++) begin
               win_in[i] = cand[i+1];
            end
            win_in[HDR_BYTES-1] = cand[HDR_BYTES-1];
         end else begin
            for (int i = 0; i < HDR_BYTES; i++) begin
               win_in[i] = cand[i];
            end
            fill_in = full ? '0 : HDR_IDX_W'(fill_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < HDR_BYTES; i++) begin
         win_ff[i] <= win_in[i];
      end
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

endmodule

// ===== design/mlfr_tx.sv =====
// ----------------------------------------------------------------------------
// mlfr_tx
// Result register with header drain: plays an accepted header out of the
// window one byte a cycle unless rsp stalls, otherwise forwards body bytes.
// ----------------------------------------------------------------------------
module mlfr_tx
   import mlfr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  tx_cmd_type           cmd,
   input  byte_type             rd_byte,
   output logic [HDR_IDX_W-1:0] rd_idx,
   output logic                 room,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output byte_type             rsp_out_byte,
   output logic                 rsp_frame_start,
   output logic                 rsp_frame_last
);

   logic                 valid_ff, valid_in;
   byte_type             byte_ff, byte_in;
   logic                 start_ff, start_in;
   logic                 last_ff, last_in;
   logic                 drain_ff, drain_in;
   logic [HDR_IDX_W-1:0] idx_ff, idx_in;
   logic                 take;

   assign take   = !valid_ff || rsp_ready;
   assign room   = take && !drain_ff;
   assign rd_idx = idx_ff;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      start_in = start_ff;
      last_in  = last_ff;
      drain_in = drain_ff;
      idx_in   = idx_ff;
      if (take) begin
         if (drain_ff) begin
            valid_in = 1'b1;
            byte_in  = rd_byte;
            start_in = (idx_ff == '0);
            last_in  = 1'b0;
            idx_in   = HDR_IDX_W'(idx_ff + 1'b1);
            if (idx_ff == HDR_IDX_W'(HDR_BYTES - 1)) begin
               drain_in = 1'b0;
            end
         end else if (cmd.body_load) begin
            valid_in = 1'b1;
            byte_in  = cmd.body_byte;
            start_in = 1'b0;
            last_in  = cmd.body_last;
         end else begin
            valid_in = 1'b0;
         end
      end
      if (cmd.hdr_load) begin
         drain_in = 1'b1;
         idx_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff  <= byte_in;
      start_ff <= start_in;
      last_ff  <= last_in;
      if (reset) begin
         valid_ff <= 1'b0;
         drain_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         drain_ff <= drain_in;
         idx_ff   <= idx_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_frame_start = start_ff;
   assign rsp_frame_last  = last_ff;

endmodule

// ===== design/magic_length_frame_resync.sv =====
// A body byte appears on rsp in the cycle after its request is taken; a good
// header passes through the drain flag, then the output register, and plays
// out all 16 bytes. One request per cycle while searching or passing a body,
// unless rsp stalls; req_ready stays low while a header plays out of the window.
// Reset (synchronous, active high) empties the window, leaves frame mode and
// restores the sync word to 0 and max_payload_words to 2^20.
// ----------------------------------------------------------------------------
// magic_length_frame_resync
// Byte-serial deframer: resynchronises on a 32-bit magic word, checks the
// word count and passes header, payload and trailer marked start and last.
// ----------------------------------------------------------------------------
module magic_length_frame_resync
   import mlfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_rx_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_frame_start,
   output logic                  rsp_frame_last,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [MAGIC_W-1:0]     magic_ff;
   logic [MAX_WORDS_W-1:0] max_words_ff;
   logic [MAX_WORDS_W-1:0] limit;
   logic                   body_ff, body_in;
   logic [REM_W-1:0]       rem_ff, rem_in;
   logic                   accept;
   logic                   room;
   logic                   body_last;
   hdr_status_type         status;
   tx_cmd_type             cmd;
   byte_type               rd_byte;
   logic [HDR_IDX_W-1:0]   rd_idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff     <= '0;
         max_words_ff <= COUNT_LIMIT;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SYNC_WORD: magic_ff     <= csr_wdata[MAGIC_W-1:0];
            CSR_MAX_WORDS: max_words_ff <= csr_wdata[MAX_WORDS_W-1:0];
            default: ;
         endcase
      end
   end

   assign limit     = (max_words_ff > COUNT_LIMIT) ? COUNT_LIMIT : max_words_ff;
   assign req_ready = room;
   assign accept    = req_valid && room;
   assign body_last = (rem_ff == REM_W'(1));

   mlfr_window u_window (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && !body_ff),
      .push_byte (req_rx_byte),
      .sync_word (magic_ff),
      .limit     (limit),
      .rd_idx    (rd_idx),
      .rd_byte   (rd_byte),
      .status    (status)
   );

   always_comb begin
      body_in = body_ff;
      rem_in  = rem_ff;
      cmd.body_load = accept && body_ff;
      cmd.body_last = body_last;
      cmd.body_byte = req_rx_byte;
      cmd.hdr_load  = accept && !body_ff && status.hdr_ok;
      if (accept) begin
         if (body_ff) begin
            rem_in = REM_W'(rem_ff - 1'b1);
            if (body_last) begin
               body_in = 1'b0;
            end
         end else if (status.hdr_ok) begin
            // payload words plus one trailer word
            body_in = 1'b1;
            rem_in  = REM_W'({status.count, 2'b00}) + REM_W'(WORD_BYTES);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         body_ff <= 1'b0;
         rem_ff  <= '0;
      end else begin
         body_ff <= body_in;
         rem_ff  <= rem_in;
      end
   end

   mlfr_tx u_tx (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .rd_byte         (rd_byte),
      .rd_idx          (rd_idx),
      .room            (room),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_frame_start (rsp_frame_start),
      .rsp_frame_last  (rsp_frame_last)
   );

endmodule
